// ===== sv/hbp_pkg.sv =====
// Package for the Huffman bit packer: item modes, state codes and length limits.
// No dependencies.
package hbp_pkg;

   localparam int CODE_W       = 32;
   localparam int LEN_W        = 6;
   localparam int MAX_CODE_LEN = 32;
   localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_ENCODE = 2'd1,
      MODE_FLUSH  = 2'd2
   } mode_type;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LOOKUP = 5'b00010,
      S_EMIT   = 5'b00100,
      S_ERR    = 5'b01000,
      S_FLUSH  = 5'b10000
   } state_type;

endpackage

// ===== sv/huffman_bit_packer.sv =====
// Table-driven Huffman encoder packing code bits into bytes, MSB first.
// Load, unused mode and empty flush stay in idle; a flush with a partial byte goes
// through S_FLUSH, a symbol without code through S_LOOKUP and S_ERR, and an encode
// through S_LOOKUP and S_EMIT, which gives n output bytes (n <= 4). In S_EMIT the
// single byte shifter sends one byte per cycle from the registered table read while
// rsp_tready does not stall it. Sync reset clears table valid bits, partial byte, output.
module huffman_bit_packer
   import hbp_pkg::*;
#(
   parameter int NUM_SYMBOLS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // symbol[7:0], code_bits[39:8], code_length[45:40], zero
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tuser,   // no_code[0]
   output logic        rsp_tlast
);

   localparam int IDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int ENT_W = LEN_W + CODE_W;

   logic [ENT_W-1:0]  table_mem [NUM_SYMBOLS];
   logic [NUM_SYMBOLS-1:0] valid_ff, valid_in;
   logic [ENT_W-1:0]  rd_ff;
   logic              hit_ff, hit_in;

   state_type         state_ff, state_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [6:0]        pend_ff, pend_in;
   logic [2:0]        cnt_ff, cnt_in;

   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_nc_ff, out_nc_in;
   logic              out_last_ff, out_last_in;

   logic [7:0]        req_symbol;
   logic [CODE_W-1:0] req_code;
   logic [LEN_W-1:0]  req_len;
   logic [LEN_W-1:0]  len_sat;
   logic [CODE_W-1:0] code_aligned;
   logic              sym_ok;
   logic              accept;
   logic              do_write;
   logic              do_read;
   logic [IDX_W-1:0]  idx;
   logic              out_free;
   logic [3:0]        room;
   logic [7:0]        full;
   logic [CODE_W-1:0] code_sh;
   logic [LEN_W-1:0]  rem_left;

   assign req_symbol = req_tdata[7:0];
   assign req_code   = req_tdata[39:8];
   assign req_len    = req_tdata[45:40];
   assign idx        = req_symbol[IDX_W-1:0];
   assign sym_ok     = {1'b0, req_symbol} < 9'(NUM_SYMBOLS);
   assign len_sat    = (req_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : req_len;
   // left-align the code; bits above the length fall off
   assign code_aligned = req_code << (LEN_W'(CODE_W) - len_sat);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign do_write   = accept && (req_tuser == MODE_LOAD) && sym_ok;
   assign do_read    = accept && (req_tuser == MODE_ENCODE);
   assign out_free   = !out_valid_ff || rsp_tready;

   assign room     = 4'd8 - {1'b0, cnt_ff};
   assign full     = {pend_ff, 1'b0} | (code_ff[CODE_W-1 -: 8] >> cnt_ff);
   assign code_sh  = code_ff << room;
   assign rem_left = rem_ff - {2'b0, room};

   always_ff @(posedge clock) begin
      if (do_write) begin
         table_mem[idx] <= {len_sat, code_aligned};
      end
      if (do_read) begin
         rd_ff <= table_mem[idx];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (do_write) begin
         valid_in[idx] = (len_sat != '0);
      end
   end

   assign hit_in = do_read ? (sym_ok && valid_ff[idx]) : hit_ff;

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_nc_in    = out_nc_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  MODE_ENCODE: state_in = S_LOOKUP;
                  MODE_FLUSH:  state_in = (cnt_ff != '0) ? S_FLUSH : S_IDLE;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_LOOKUP: begin
            code_in  = rd_ff[CODE_W-1:0];
            rem_in   = rd_ff[ENT_W-1 -: LEN_W];
            state_in = hit_ff ? S_EMIT : S_ERR;
         end
         S_EMIT: begin
            if (rem_ff < {2'b0, room}) begin
               pend_in  = full[7:1];
               cnt_in   = cnt_ff + rem_ff[2:0];
               state_in = S_IDLE;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = full;
               out_nc_in    = 1'b0;
               code_in      = code_sh;
               rem_in       = rem_left;
               if (rem_left < LEN_W'(8)) begin
                  out_last_in = 1'b1;
                  pend_in     = code_sh[CODE_W-1 -: 7];
                  cnt_in      = rem_left[2:0];
                  state_in    = S_IDLE;
               end else begin
                  out_last_in = 1'b0;
                  pend_in     = '0;
                  cnt_in      = '0;
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = '0;
               out_nc_in    = 1'b1;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = {pend_ff, 1'b0};
               out_nc_in    = 1'b0;
               out_last_in  = 1'b1;
               pend_in      = '0;
               cnt_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         pend_ff      <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      code_ff     <= code_in;
      rem_ff      <= rem_in;
      out_byte_ff <= out_byte_in;
      out_nc_ff   <= out_nc_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_nc_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== bench/tb.sv =====
// Testbench for huffman_bit_packer: directed and random load, encode, flush and unused-mode words,
// with a built-in byte packing predictor checking every output word in order.
// Depends on hbp_pkg and the huffman_bit_packer RTL.
`timescale 1ns / 1ps

module tb;
   import hbp_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int         CYCLE_LIMIT = 100000;

   typedef struct packed {
      logic [7:0] value;
      logic       no_code;
      logic       last;
   } packed_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // symbol[7:0], code_bits[39:8], code_length[45:40], zero
   logic [1:0]  req_tuser = '0;    // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // out_byte[7:0]
   logic        rsp_tuser;         // no_code[0]
   logic        rsp_tlast;

   huffman_bit_packer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [31:0]  tbl_code [256];
   logic [5:0]   tbl_len  [256];
   logic [6:0]   part_bits = '0;
   logic [2:0]   part_cnt  = '0;
   packed_byte_type byte_q [$];
   int           live_syms [$];

   int           errors = 0;
   int           cycles = 0;
   bit           idle_on = 1'b1;
   int unsigned  hold_cnt = 0;

   initial begin
      for (int i = 0; i < 256; i++) begin
         tbl_code[i] = '0;
         tbl_len[i]  = '0;
      end
   end

   task automatic push_byte(logic [7:0] value, logic no_code, logic last);
      packed_byte_type r;
      r.value   = value;
      r.no_code = no_code;
      r.last    = last;
      byte_q.push_back(r);
   endtask

   task automatic predict_packed_bytes(logic [1:0] mode, logic [7:0] sym, logic [31:0] bits,
                                       logic [5:0] len);
      logic [63:0] acc;
      int          cnt;
      int          clen;
      case (mode)
         MODE_LOAD: begin
            tbl_code[sym] = bits;
            tbl_len[sym]  = (len > LEN_CAP) ? 6'(LEN_CAP) : len;
         end
         MODE_ENCODE: begin
            if (tbl_len[sym] == 0) begin
               push_byte(8'h00, 1'b1, 1'b1);
            end else begin
               clen = tbl_len[sym];
               acc  = ({57'd0, part_bits} << clen)
                    | ({32'd0, tbl_code[sym]} & ((64'd1 << clen) - 64'd1));
               cnt  = part_cnt + clen;
               while (cnt >= 8) begin
                  push_byte(8'(acc >> (cnt - 8)), 1'b0, (cnt - 8) < 8);
                  cnt -= 8;
               end
               part_bits = 7'(acc & ((64'd1 << cnt) - 64'd1));
               part_cnt  = 3'(cnt);
            end
         end
         MODE_FLUSH: begin
            if (part_cnt != 0) begin
               push_byte(8'({1'b0, part_bits} << (8 - part_cnt)), 1'b0, 1'b1);
               part_bits = '0;
               part_cnt  = '0;
            end
         end
         default: ;
      endcase
   endtask

   // starts and ends at a falling edge
   task automatic send_word(logic [1:0] mode, logic [7:0] sym, logic [31:0] bits,
                            logic [5:0] len);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {2'b00, len, bits, sym};
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_packed_bytes(mode, sym, bits, len);
      if (mode == MODE_LOAD && tbl_len[sym] != 0)
         live_syms.push_back(sym);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      wait (byte_q.size() == 0);
      @(negedge clock);
   endtask

   task automatic send_random_word();
      int          pick;
      logic [7:0]  sym;
      logic [5:0]  len;
      pick = $urandom_range(0, 99);
      sym  = 8'($urandom_range(0, 255));
      if (pick < 18) begin
         case ($urandom_range(0, 9))
            0:       len = 6'd0;
            1:       len = 6'($urandom_range(33, 63));
            2:       len = 6'd32;
            default: len = 6'($urandom_range(1, 12));
         endcase
         send_word(MODE_LOAD, sym, $urandom, len);
      end else if (pick < 85) begin
         if (live_syms.size() != 0 && $urandom_range(0, 9) != 0)
            sym = 8'(live_syms[$urandom_range(0, live_syms.size() - 1)]);
         send_word(MODE_ENCODE, sym, $urandom, 6'($urandom_range(0, 63)));
      end else if (pick < 95) begin
         send_word(MODE_FLUSH, sym, $urandom, 6'($urandom_range(0, 63)));
      end else begin
         send_word(MODE_SPARE, sym, $urandom, 6'($urandom_range(0, 63)));
      end
   endtask

   task automatic test_directed_codes();
      send_word(MODE_ENCODE, 8'h00, 32'h0,         6'd0);   // symbol without code
      send_word(MODE_FLUSH,  8'h00, 32'h0,         6'd0);   // empty flush
      send_word(MODE_SPARE,  8'hFF, 32'hFFFFFFFF,  6'd63);  // unused mode
      send_word(MODE_LOAD,   8'h00, 32'hFFFFFFFF,  6'd1);   // bits above length ignored
      send_word(MODE_LOAD,   8'hFF, 32'hA5C396F0,  6'd32);
      send_word(MODE_LOAD,   8'h01, 32'h12345678,  6'd63);  // length saturates
      send_word(MODE_LOAD,   8'h02, 32'hFFFFFFFF,  6'd0);
      send_word(MODE_LOAD,   8'h03, 32'h00000055,  6'd7);
      send_word(MODE_LOAD,   8'h04, 32'h00000000,  6'd8);
      send_word(MODE_LOAD,   8'hC8, 32'h0F0F0F0F,  6'd33);
      send_word(MODE_ENCODE, 8'h00, 32'h0,         6'd0);   // one bit, no full byte
      send_word(MODE_ENCODE, 8'h03, 32'h0,         6'd0);
      send_word(MODE_ENCODE, 8'hFF, 32'h0,         6'd0);
      send_word(MODE_ENCODE, 8'h01, 32'h0,         6'd0);
      send_word(MODE_ENCODE, 8'h02, 32'h0,         6'd0);   // loaded with length 0, so no code
      send_word(MODE_ENCODE, 8'h00, 32'h0,         6'd0);
      send_word(MODE_FLUSH,  8'h00, 32'h0,         6'd0);
      send_word(MODE_FLUSH,  8'h00, 32'h0,         6'd0);
      send_word(MODE_ENCODE, 8'h04, 32'h0,         6'd0);
      send_word(MODE_ENCODE, 8'hC8, 32'h0,         6'd0);
      send_word(MODE_ENCODE, 8'h00, 32'h0,         6'd0);
      send_word(MODE_ENCODE, 8'hFF, 32'h0,         6'd0);
      send_word(MODE_FLUSH,  8'h00, 32'h0,         6'd0);
   endtask

   task automatic test_random_stream(int count);
      for (int i = 0; i < count; i++)
         send_random_word();
   endtask

   task automatic test_held_sender();
      for (int i = 0; i < 4; i++)
         send_random_word();
      wait_drained();
   endtask

   task automatic test_no_idle_tail(int count);
      idle_on = 1'b0;
      test_random_stream(count);
   endtask

   always @(negedge clock) begin
      if (hold_cnt != 0) begin
         hold_cnt   <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         hold_cnt   <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      packed_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (byte_q.size() == 0) begin
            $error("unexpected word: out_byte %h no_code %b last %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            want = byte_q.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("out_byte: expected %h, got %h", want.value, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== want.no_code) begin
               $error("no_code: expected %b, got %b", want.no_code, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_codes();
      test_held_sender();
      test_random_stream(40);
      test_held_sender();
      test_random_stream(20);
      test_no_idle_tail(30);
      wait_drained();
      repeat (16) @(negedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
